/* hw/rtl/field_potential_matvec_top_assert.svh */
// Assertion macros shared by the field potential block.
`ifndef FIELD_POTENTIAL_MATVEC_TOP_ASSERT_SVH
`define FIELD_POTENTIAL_MATVEC_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fpm_pkg.sv */
// Types and constants shared by the field potential matrix-vector block.
`default_nettype none

package fpm_pkg;

  // Fixed field widths of the channels.
  localparam int OpW      = 2;
  localparam int ElecW    = 4;
  localparam int SegW     = 8;
  localparam int NodeW    = 8;
  localparam int ValW     = 32;
  localparam int AccW     = 64;
  localparam int CfgAddrW = 8;
  localparam int CfgDataW = 32;
  localparam int ECountW  = 5;
  localparam int SCountW  = 9;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] REG_ELECTRODE_COUNT = 8'd0;
  localparam logic [CfgAddrW-1:0] REG_SEGMENT_COUNT   = 8'd1;

  // Input word opcodes.
  typedef enum logic [OpW-1:0] {
    OP_LOAD_COEF    = 2'd0,
    OP_LOAD_MAP     = 2'd1,
    OP_LOAD_CURRENT = 2'd2,
    OP_COMPUTE      = 2'd3
  } fpm_op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } fpm_state_e;

  // Flags that travel with one product through the datapath.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

  // Store write request, decoded from a load word.
  typedef struct packed {
    logic                   coef_we;
    logic                   map_we;
    logic                   curr_we;
    logic [ElecW-1:0]       elec;
    logic [SegW-1:0]        seg;
    logic [NodeW-1:0]       node;
    logic signed [ValW-1:0] value;
  } wr_req_t;

  // Store read request for one product term.
  typedef struct packed {
    tag_t               tag;
    logic [ECountW-1:0] elec;
    logic [SCountW-1:0] seg;
  } rd_req_t;

  // Operand pair handed to the multiply-accumulate unit.
  typedef struct packed {
    tag_t                   tag;
    logic signed [ValW-1:0] coef;
    logic signed [ValW-1:0] curr;
  } mac_op_t;

endpackage

`default_nettype wire

/* hw/rtl/fpm_if.sv */
// Handshake channel interfaces for input words, result words and configuration writes.
`default_nettype none

interface fpm_in_if;
  logic                           valid;
  logic                           ready;
  logic [fpm_pkg::OpW-1:0]        opcode;
  logic [fpm_pkg::ElecW-1:0]      electrode_index;
  logic [fpm_pkg::SegW-1:0]       segment_index;
  logic [fpm_pkg::NodeW-1:0]      node_index;
  logic signed [fpm_pkg::ValW-1:0] value;

  modport source (output valid, opcode, electrode_index, segment_index, node_index, value,
                  input ready);
  modport sink (input valid, opcode, electrode_index, segment_index, node_index, value,
                output ready);
endinterface

interface fpm_out_if;
  logic                            valid;
  logic                            ready;
  logic [fpm_pkg::ElecW-1:0]       electrode_out;
  logic signed [fpm_pkg::AccW-1:0] potential;
  logic                            last;

  modport source (output valid, electrode_out, potential, last, input ready);
  modport sink (input valid, electrode_out, potential, last, output ready);
endinterface

interface fpm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fpm_pkg::CfgAddrW-1:0] addr;
  logic [fpm_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fpm_store.sv */
// Coefficient, segment map and current memories with a two-stage gather read.
`default_nettype none

module fpm_store #(
  parameter int MAX_ELECTRODES = 16,
  parameter int MAX_SEGMENTS   = 256,
  parameter int MAX_NODES      = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpm_pkg::wr_req_t wr_i,
  input  fpm_pkg::rd_req_t rd_i,
  output fpm_pkg::mac_op_t op_o
);

  localparam int EIdxW     = (MAX_ELECTRODES > 1) ? $clog2(MAX_ELECTRODES) : 1;
  localparam int SIdxW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int NIdxW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CoefDepth = MAX_ELECTRODES * (2 ** SIdxW);

  logic signed [fpm_pkg::ValW-1:0]  coef_mem [CoefDepth];
  logic [fpm_pkg::NodeW-1:0]        map_mem  [MAX_SEGMENTS];
  logic signed [fpm_pkg::ValW-1:0]  curr_mem [MAX_NODES];

  logic [fpm_pkg::NodeW-1:0]        map_rd_q;
  logic [EIdxW+SIdxW-1:0]           coef_addr_q;
  logic signed [fpm_pkg::ValW-1:0]  coef_q;
  logic signed [fpm_pkg::ValW-1:0]  curr_q;
  fpm_pkg::tag_t                    tag1_q, tag2_q;

  // Load writes; the sequencer never reads while a load is in flight.
  always_ff @(posedge clk_i) begin
    if (wr_i.coef_we) begin
      coef_mem[{EIdxW'(wr_i.elec), SIdxW'(wr_i.seg)}] <= wr_i.value;
    end
    if (wr_i.map_we) begin
      map_mem[SIdxW'(wr_i.seg)] <= wr_i.node;
    end
    if (wr_i.curr_we) begin
      curr_mem[NIdxW'(wr_i.node)] <= wr_i.value;
    end
  end

  // Stage one looks up the node of the segment and holds the coefficient address.
  // Stage two reads the gathered current and the coefficient side by side.
  always_ff @(posedge clk_i) begin
    map_rd_q    <= map_mem[SIdxW'(rd_i.seg)];
    coef_addr_q <= {EIdxW'(rd_i.elec), SIdxW'(rd_i.seg)};
    curr_q      <= curr_mem[NIdxW'(map_rd_q)];
    coef_q      <= coef_mem[coef_addr_q];
  end

  // Flags follow the data through both read stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= rd_i.tag;
      tag2_q <= tag1_q;
    end
  end

  assign op_o.tag  = tag2_q;
  assign op_o.coef = coef_q;
  assign op_o.curr = curr_q;

endmodule

`default_nettype wire

/* hw/rtl/fpm_mac.sv */
// Shared multiply-accumulate unit: one Q16.16 product per cycle into a saturating Q32.32 sum.
`default_nettype none

module fpm_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fpm_pkg::mac_op_t                op_i,
  output logic signed [fpm_pkg::AccW-1:0] acc_o,
  output logic                            done_o
);

  localparam logic signed [fpm_pkg::AccW-1:0] AccMax = {1'b0, {(fpm_pkg::AccW-1){1'b1}}};
  localparam logic signed [fpm_pkg::AccW-1:0] AccMin = {1'b1, {(fpm_pkg::AccW-1){1'b0}}};

  logic signed [fpm_pkg::AccW-1:0] prod_q;
  fpm_pkg::tag_t                   ptag_q;
  logic signed [fpm_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [fpm_pkg::AccW-1:0] base, sum;
  logic                            ovf;
  logic                            done_q;

  // Full-precision product, registered before the add.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(op_i.coef) * $signed(op_i.curr);
  end

  // Saturating add; the first term of a row starts from zero.
  always_comb begin
    base  = ptag_q.first ? '0 : acc_q;
    sum   = base + prod_q;
    ovf   = (base[fpm_pkg::AccW-1] == prod_q[fpm_pkg::AccW-1]) &&
            (sum[fpm_pkg::AccW-1] != base[fpm_pkg::AccW-1]);
    acc_d = acc_q;
    if (ptag_q.valid) begin
      if (ovf) begin
        acc_d = prod_q[fpm_pkg::AccW-1] ? AccMin : AccMax;
      end else begin
        acc_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Control flags of the unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptag_q <= '0;
      done_q <= 1'b0;
    end else begin
      ptag_q <= op_i.tag;
      done_q <= ptag_q.valid && ptag_q.last;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hw/rtl/field_potential_matvec_top.sv */
// Field potential block: stores, sequencer and the shared multiply-accumulate unit.
`default_nettype none
`include "field_potential_matvec_top_assert.svh"

// Computes electrode field potentials as a saturating Q32.32 sum of stored Q16.16
// coefficients times membrane currents gathered through a segment-to-node map.
// Load words (coefficient, map entry, current) are taken while idle. A compute word
// then occupies the block: for each electrode in use one product is issued per cycle
// through the single shared multiplier, then the row drains through the store read,
// multiply and accumulate registers before its result word is handed off. The word
// input is not ready from the compute word until its last result word has been
// taken. The memories have no reset or clearing pass.
module field_potential_matvec_top #(
  parameter int MAX_ELECTRODES = 16,
  parameter int MAX_SEGMENTS   = 256,
  parameter int MAX_NODES      = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpm_in_if.sink    in_i,
  fpm_cfg_if.sink   cfg_i,
  fpm_out_if.source out_o
);

  localparam int EW = fpm_pkg::ECountW;
  localparam int SW = fpm_pkg::SCountW;

  fpm_pkg::fpm_state_e state_q, state_d;
  logic [EW-1:0] elec_count_q;
  logic [SW-1:0] seg_count_q;
  logic [EW-1:0] ne_q, ne_d, k_q, k_d, k_nxt, ne_eff;
  logic [SW-1:0] ns_q, ns_d, l_q, l_d, ns_eff;

  logic [fpm_pkg::ElecW-1:0]       elec_out_q, elec_out_d;
  logic signed [fpm_pkg::AccW-1:0] pot_q, pot_d;
  logic                            last_q, last_d;

  fpm_pkg::wr_req_t                wr_req;
  fpm_pkg::rd_req_t                rd_req;
  fpm_pkg::mac_op_t                mac_op;
  logic signed [fpm_pkg::AccW-1:0] mac_acc;
  logic                            mac_done;
  logic                            in_fire;

  // Configuration registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elec_count_q <= EW'(1);
      seg_count_q  <= SW'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        fpm_pkg::REG_ELECTRODE_COUNT: elec_count_q <= cfg_i.wdata[EW-1:0];
        fpm_pkg::REG_SEGMENT_COUNT:   seg_count_q  <= cfg_i.wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Counts in effect, limited to the store sizes.
  assign ne_eff = (elec_count_q > MAX_ELECTRODES) ? EW'(MAX_ELECTRODES) : elec_count_q;
  assign ns_eff = (seg_count_q > MAX_SEGMENTS) ? SW'(MAX_SEGMENTS) : seg_count_q;

  assign in_fire = in_i.valid && in_i.ready;
  assign k_nxt   = k_q + EW'(1);

  // Load decode; an index past its store is dropped.
  always_comb begin
    wr_req         = '0;
    wr_req.elec    = in_i.electrode_index;
    wr_req.seg     = in_i.segment_index;
    wr_req.node    = in_i.node_index;
    wr_req.value   = in_i.value;
    if (in_fire) begin
      case (in_i.opcode)
        fpm_pkg::OP_LOAD_COEF: begin
          wr_req.coef_we = (32'(in_i.electrode_index) < MAX_ELECTRODES) &&
                           (32'(in_i.segment_index) < MAX_SEGMENTS);
        end
        fpm_pkg::OP_LOAD_MAP: begin
          wr_req.map_we = (32'(in_i.segment_index) < MAX_SEGMENTS) &&
                          (32'(in_i.node_index) < MAX_NODES);
        end
        fpm_pkg::OP_LOAD_CURRENT: begin
          wr_req.curr_we = (32'(in_i.node_index) < MAX_NODES);
        end
        default: ;
      endcase
    end
  end

  // Sequencer: issue one product per cycle for a row, drain, then hand off the result.
  always_comb begin
    state_d    = state_q;
    ne_d       = ne_q;
    ns_d       = ns_q;
    k_d        = k_q;
    l_d        = l_q;
    elec_out_d = elec_out_q;
    pot_d      = pot_q;
    last_d     = last_q;
    rd_req     = '0;
    rd_req.elec = k_q;
    rd_req.seg  = l_q;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    case (state_q)
      fpm_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && (in_i.opcode == fpm_pkg::OP_COMPUTE)) begin
          ne_d = ne_eff;
          ns_d = ns_eff;
          k_d  = '0;
          l_d  = '0;
          if (ne_eff == '0) begin
            state_d = fpm_pkg::ST_IDLE;
          end else if (ns_eff == '0) begin
            elec_out_d = '0;
            pot_d      = '0;
            last_d     = (ne_eff == EW'(1));
            state_d    = fpm_pkg::ST_OUT;
          end else begin
            state_d = fpm_pkg::ST_ISSUE;
          end
        end
      end
      fpm_pkg::ST_ISSUE: begin
        rd_req.tag.valid = 1'b1;
        rd_req.tag.first = (l_q == '0);
        rd_req.tag.last  = (l_q == ns_q - SW'(1));
        l_d = l_q + SW'(1);
        if (rd_req.tag.last) begin
          state_d = fpm_pkg::ST_DRAIN;
        end
      end
      fpm_pkg::ST_DRAIN: begin
        if (mac_done) begin
          pot_d      = mac_acc;
          elec_out_d = k_q[fpm_pkg::ElecW-1:0];
          last_d     = (k_q == ne_q - EW'(1));
          state_d    = fpm_pkg::ST_OUT;
        end
      end
      fpm_pkg::ST_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          if (last_q) begin
            state_d = fpm_pkg::ST_IDLE;
          end else begin
            k_d = k_nxt;
            l_d = '0;
            if (ns_q == '0) begin
              pot_d      = '0;
              elec_out_d = k_nxt[fpm_pkg::ElecW-1:0];
              last_d     = (k_nxt == ne_q - EW'(1));
            end else begin
              state_d = fpm_pkg::ST_ISSUE;
            end
          end
        end
      end
      default: state_d = fpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpm_pkg::ST_IDLE;
      ne_q    <= '0;
      ns_q    <= '0;
      k_q     <= '0;
      l_q     <= '0;
    end else begin
      state_q <= state_d;
      ne_q    <= ne_d;
      ns_q    <= ns_d;
      k_q     <= k_d;
      l_q     <= l_d;
    end
  end

  // Result word holding register.
  always_ff @(posedge clk_i) begin
    elec_out_q <= elec_out_d;
    pot_q      <= pot_d;
    last_q     <= last_d;
  end

  assign out_o.electrode_out = elec_out_q;
  assign out_o.potential     = pot_q;
  assign out_o.last          = last_q;

  fpm_store #(
    .MAX_ELECTRODES (MAX_ELECTRODES),
    .MAX_SEGMENTS   (MAX_SEGMENTS),
    .MAX_NODES      (MAX_NODES)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr_req),
    .rd_i   (rd_req),
    .op_o   (mac_op)
  );

  fpm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  // A pending result word keeps the input closed.
  `FPM_ASSERT_IMP(a_out_blocks_in, out_o.valid, !in_i.ready, "input open while result pending")
  // A finished row only comes back while the sequencer waits for it.
  `FPM_ASSERT_IMP(a_done_in_drain, mac_done, state_q == fpm_pkg::ST_DRAIN, "stray row done")
  // The flagged word carries the final electrode of the run.
  `FPM_ASSERT_IMP(a_last_elec, out_o.valid && out_o.last,
                  out_o.electrode_out == fpm_pkg::ElecW'(ne_q - EW'(1)), "last on wrong electrode")
  // Taking the flagged word ends the run.
  `FPM_ASSERT_NXT(a_last_idle, out_o.valid && out_o.ready && out_o.last,
                  state_q == fpm_pkg::ST_IDLE, "run did not end after last word")

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the field potential matrix-vector block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpm_pkg::*;

  localparam int MAX_ELEC = 16;
  localparam int MAX_SEG  = 256;
  localparam int MAX_NODE = 256;

  localparam logic signed [ValW-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [ValW-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [ValW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [AccW-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [AccW-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // Register indexes past the two real registers, which the block ignores.
  localparam logic [CfgAddrW-1:0] REG_SPARE_FIRST = 8'd2;
  localparam logic [CfgAddrW-1:0] REG_SPARE_LAST  = 8'hFF;

  localparam int SETTLE_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES  = 600;
  localparam longint TIMEOUT_NS    = 5_000_000;

  // One input word and one result word.
  typedef struct {
    fpm_op_e                op;
    logic [ElecW-1:0]       e;
    logic [SegW-1:0]        s;
    logic [NodeW-1:0]       n;
    logic signed [ValW-1:0] v;
  } fpm_word_t;

  typedef struct {
    logic [ElecW-1:0]       electrode;
    logic signed [AccW-1:0] potential;
    logic                   last;
  } potential_word_t;

  // One row of the directed table: a register write or an input word,
  // optionally with a hand-computed single potential.
  typedef struct {
    bit                     is_reg;
    fpm_word_t              w;
    logic [CfgAddrW-1:0]    addr;
    logic [CfgDataW-1:0]    data;
    bit                     typed;
    logic signed [AccW-1:0] pot;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fpm_in_if  in_bus ();
  fpm_cfg_if cfg_bus ();
  fpm_out_if out_bus ();

  field_potential_matvec_top #(
    .MAX_ELECTRODES(MAX_ELEC),
    .MAX_SEGMENTS  (MAX_SEG),
    .MAX_NODES     (MAX_NODE)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .cfg_i (cfg_bus),
    .out_o (out_bus)
  );

  // Shadow copy of the block's stores and registers.
  logic signed [ValW-1:0] coef_mem    [MAX_ELEC][MAX_SEG];
  logic [NodeW-1:0]       node_map    [MAX_SEG];
  logic signed [ValW-1:0] current_mem [MAX_NODE];
  bit                     coef_set    [MAX_ELEC][MAX_SEG];
  bit                     map_set     [MAX_SEG];
  bit                     curr_set    [MAX_NODE];
  logic [ECountW-1:0]     ecount_q = 5'd1;
  logic [SCountW-1:0]     scount_q = 9'd1;

  potential_word_t expected_potentials[$];
  int mismatch_count = 0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit rx_hold      = 1'b0;
  bit hold_go      = 1'b0;

  stim_row_t directed[$];

  always #5 clk_i = ~clk_i;

  function automatic int used_electrodes();
    return (ecount_q > MAX_ELEC) ? MAX_ELEC : int'(ecount_q);
  endfunction

  function automatic int used_segments();
    return (scount_q > MAX_SEG) ? MAX_SEG : int'(scount_q);
  endfunction

  // Apply one accepted word to the shadow state; a compute queues one
  // saturated potential per electrode in use.
  function automatic void predict_potentials(fpm_word_t w);
    int ne;
    int ns;
    longint acc;
    longint c;
    longint i;
    longint prod;
    longint sum;
    potential_word_t r;
    case (w.op)
      OP_LOAD_COEF: begin
        coef_mem[w.e][w.s] = w.v;
        coef_set[w.e][w.s] = 1'b1;
      end
      OP_LOAD_MAP: begin
        node_map[w.s] = w.n;
        map_set[w.s]  = 1'b1;
      end
      OP_LOAD_CURRENT: begin
        current_mem[w.n] = w.v;
        curr_set[w.n]    = 1'b1;
      end
      default: begin
        ne = used_electrodes();
        ns = used_segments();
        for (int k = 0; k < ne; k++) begin
          acc = 0;
          for (int l = 0; l < ns; l++) begin
            c    = coef_mem[k][l];
            i    = current_mem[node_map[l]];
            prod = c * i;
            sum  = acc + prod;
            // Clamp when both addends share a sign that the sum lost.
            if (acc[63] == prod[63] && sum[63] != acc[63]) begin
              sum = acc[63] ? ACC_MIN : ACC_MAX;
            end
            acc = sum;
          end
          r.electrode = 4'(k);
          r.potential = acc;
          r.last      = (k + 1 == ne);
          expected_potentials.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic fpm_word_t make_word(fpm_op_e op, int e, int s, int n,
                                          logic [ValW-1:0] v);
    fpm_word_t w;
    w.op = op;
    w.e  = 4'(e);
    w.s  = 8'(s);
    w.n  = 8'(n);
    w.v  = v;
    return w;
  endfunction

  function automatic stim_row_t row_w(fpm_op_e op, int e, int s, int n,
                                      logic [ValW-1:0] v);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.addr   = '0;
    r.data   = '0;
    r.typed  = 1'b0;
    r.pot    = '0;
    r.w      = make_word(op, e, s, n, v);
    return r;
  endfunction

  function automatic stim_row_t row_c(logic signed [AccW-1:0] pot);
    stim_row_t r;
    r       = row_w(OP_COMPUTE, 0, 0, 0, '0);
    r.typed = 1'b1;
    r.pot   = pot;
    return r;
  endfunction

  function automatic stim_row_t row_r(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    stim_row_t r;
    r        = row_w(OP_LOAD_COEF, 0, 0, 0, '0);
    r.is_reg = 1'b1;
    r.addr   = addr;
    r.data   = data;
    return r;
  endfunction

  // Mix of extreme, small and fully random Q16.16 values.
  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3, 4: return 32'(int'($urandom_range(8 << 16)) - (4 << 16));
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_index(int lim, int full);
    if (lim > 0 && $urandom_range(99) < 75) return $urandom_range(lim - 1);
    return $urandom_range(full - 1);
  endfunction

  function automatic int pick_node();
    return ($urandom_range(99) < 60) ? $urandom_range(15) : $urandom_range(MAX_NODE - 1);
  endfunction

  // Drive one word and hold it until it is accepted. Called and returns at
  // a falling edge; valid is left high so back-to-back words need no dip.
  task automatic send_word(fpm_word_t w, bit typed, logic signed [AccW-1:0] pot);
    potential_word_t r;
    in_bus.valid           <= 1'b1;
    in_bus.opcode          <= w.op;
    in_bus.electrode_index <= w.e;
    in_bus.segment_index   <= w.s;
    in_bus.node_index      <= w.n;
    in_bus.value           <= w.v;
    do @(posedge clk_i); while (!in_bus.ready);
    if (typed) begin
      r.electrode = '0;
      r.potential = pot;
      r.last      = 1'b1;
      expected_potentials.push_back(r);
    end else begin
      predict_potentials(w);
    end
    @(negedge clk_i);
  endtask

  // Random sender gap, then the word.
  task automatic offer_word(fpm_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    send_word(w, 1'b0, '0);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= addr;
    cfg_bus.wdata <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (addr == REG_ELECTRODE_COUNT) begin
      ecount_q = data[ECountW-1:0];
    end else if (addr == REG_SEGMENT_COUNT) begin
      scount_q = data[SCountW-1:0];
    end
    @(negedge clk_i);
  endtask

  // Stop offering words until every expected potential is in, then let the
  // block finish any compute that had nothing to return.
  task automatic wait_drained(int settle);
    in_bus.valid <= 1'b0;
    do @(negedge clk_i); while (expected_potentials.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  // Load every entry that the next compute will read and that was never written.
  task automatic fill_operands();
    int ne;
    int ns;
    ne = used_electrodes();
    ns = used_segments();
    for (int k = 0; k < ne; k++) begin
      for (int l = 0; l < ns; l++) begin
        if (!coef_set[k][l]) begin
          offer_word(make_word(OP_LOAD_COEF, k, l, $urandom_range(255), rand_value()));
        end
      end
    end
    for (int l = 0; l < ns; l++) begin
      if (!map_set[l]) begin
        offer_word(make_word(OP_LOAD_MAP, $urandom_range(15), l, pick_node(), $urandom()));
      end
      if (!curr_set[node_map[l]]) begin
        offer_word(make_word(OP_LOAD_CURRENT, $urandom_range(15), $urandom_range(255),
                             node_map[l], rand_value()));
      end
    end
  endtask

  // One random phase: set both counts and a spare register while idle, then a
  // mix of loads, computes and stray words under the given idling.
  task automatic run_phase(int ec, int sc, int tx_pct, int rx_pct, int n_items,
                           bit long_hold);
    int r;
    int ne;
    int ns;
    logic [CfgDataW-1:0] junk;
    wait_drained(SETTLE_CYCLES);
    junk = $urandom_range(1) ? $urandom() : '0;
    write_reg(REG_ELECTRODE_COUNT, (junk & ~32'h1F) | 32'(ec));
    write_reg(REG_SEGMENT_COUNT, (junk & ~32'h1FF) | 32'(sc));
    write_reg(8'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
    cfg_bus.valid <= 1'b0;
    tx_idle_pct  = tx_pct;
    rx_stall_pct <= rx_pct;
    if (long_hold) hold_go <= 1'b1;
    ne = used_electrodes();
    ns = used_segments();
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        fill_operands();
        offer_word(make_word(OP_COMPUTE, $urandom_range(15), $urandom_range(255),
                             $urandom_range(255), $urandom()));
      end else if (r < 50) begin
        offer_word(make_word(OP_LOAD_COEF, pick_index(ne, MAX_ELEC), pick_index(ns, MAX_SEG),
                             $urandom_range(255), rand_value()));
      end else if (r < 65) begin
        offer_word(make_word(OP_LOAD_MAP, $urandom_range(15), pick_index(ns, MAX_SEG),
                             pick_node(), $urandom()));
      end else if (r < 80) begin
        offer_word(make_word(OP_LOAD_CURRENT, $urandom_range(15), $urandom_range(255),
                             $urandom_range(1) ? int'(node_map[pick_index(ns, MAX_SEG)])
                                               : pick_node(),
                             rand_value()));
      end else begin
        // Stray loads anywhere in the stores.
        offer_word(make_word(fpm_op_e'($urandom_range(2)), $urandom_range(15),
                             $urandom_range(255), $urandom_range(255), $urandom()));
      end
      // Halfway through, hold the sender until the block has emptied.
      if (k == n_items / 2) wait_drained(0);
    end
  endtask

  // Result receiver: random stalls plus the long hold-off when asked.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    potential_word_t exp_w;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_potentials.size() == 0) begin
        $display("%0t: unexpected result, electrode %0d potential %h last %0b", $time,
                 out_bus.electrode_out, out_bus.potential, out_bus.last);
        mismatch_count++;
      end else begin
        exp_w = expected_potentials.pop_front();
        if (out_bus.electrode_out !== exp_w.electrode) begin
          $display("%0t: electrode mismatch, expected %0d, actual %0d", $time,
                   exp_w.electrode, out_bus.electrode_out);
          mismatch_count++;
        end
        if (out_bus.potential !== exp_w.potential) begin
          $display("%0t: potential mismatch, expected %h, actual %h", $time,
                   exp_w.potential, out_bus.potential);
          mismatch_count++;
        end
        if (out_bus.last !== exp_w.last) begin
          $display("%0t: last flag mismatch, expected %0b, actual %0b", $time,
                   exp_w.last, out_bus.last);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, final drain.
  initial begin
    rst_ni                 = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.opcode          = OP_LOAD_COEF;
    in_bus.electrode_index = '0;
    in_bus.segment_index   = '0;
    in_bus.node_index      = '0;
    in_bus.value           = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.addr           = '0;
    cfg_bus.wdata          = '0;

    // Reset counts are one electrode and one segment: 1.0 * 1.0.
    directed.push_back(row_w(OP_LOAD_COEF, 0, 0, 0, Q_ONE));
    directed.push_back(row_w(OP_LOAD_MAP, 0, 0, 0, '0));
    directed.push_back(row_w(OP_LOAD_CURRENT, 0, 0, 0, Q_ONE));
    directed.push_back(row_c(64'sh0000_0001_0000_0000));
    // Most negative times most negative gives the largest product.
    directed.push_back(row_w(OP_LOAD_COEF, 0, 0, 0, Q_MIN));
    directed.push_back(row_w(OP_LOAD_CURRENT, 0, 0, 0, Q_MIN));
    directed.push_back(row_c(64'sh4000_0000_0000_0000));
    // Highest indexes of every field.
    directed.push_back(row_w(OP_LOAD_COEF, 15, 255, 255, Q_MAX));
    directed.push_back(row_w(OP_LOAD_MAP, 15, 255, 255, Q_MAX));
    directed.push_back(row_w(OP_LOAD_CURRENT, 15, 255, 255, Q_MAX));
    // Two largest products overflow to the positive limit.
    directed.push_back(row_r(REG_SEGMENT_COUNT, 32'd2));
    directed.push_back(row_w(OP_LOAD_COEF, 0, 1, 0, Q_MIN));
    directed.push_back(row_w(OP_LOAD_MAP, 0, 1, 0, '0));
    directed.push_back(row_c(ACC_MAX));
    directed.push_back(row_w(OP_LOAD_COEF, 0, 1, 0, Q_MAX));
    directed.push_back(row_c(64'sh0000_0000_8000_0000));
    // Clamp, then a negative product pulls the sum back down.
    directed.push_back(row_r(REG_SEGMENT_COUNT, 32'd3));
    directed.push_back(row_w(OP_LOAD_COEF, 0, 1, 0, Q_MIN));
    directed.push_back(row_w(OP_LOAD_COEF, 0, 2, 0, Q_MAX));
    directed.push_back(row_w(OP_LOAD_MAP, 0, 2, 0, '0));
    directed.push_back(row_c(64'sh4000_0000_7FFF_FFFF));
    // Three large negative products overflow to the negative limit.
    directed.push_back(row_w(OP_LOAD_CURRENT, 0, 0, 0, Q_MAX));
    directed.push_back(row_w(OP_LOAD_COEF, 0, 2, 0, Q_MIN));
    directed.push_back(row_c(ACC_MIN));
    // No segments: the potential is zero. A spare register changes nothing.
    directed.push_back(row_r(REG_SEGMENT_COUNT, 32'd0));
    directed.push_back(row_r(REG_SPARE_FIRST, 32'hFFFF_FFFF));
    directed.push_back(row_c(64'sh0));
    // No electrodes: a compute returns nothing.
    directed.push_back(row_r(REG_ELECTRODE_COUNT, 32'd0));
    directed.push_back(row_w(OP_COMPUTE, 15, 255, 255, Q_MAX));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        wait_drained(SETTLE_CYCLES);
        write_reg(directed[i].addr, directed[i].data);
        cfg_bus.valid <= 1'b0;
      end else begin
        send_word(directed[i].w, directed[i].typed, directed[i].pot);
      end
    end

    run_phase(3, 4, 0, 0, 30, 1'b0);
    run_phase(31, 2, 45, 0, 30, 1'b0);
    run_phase(1, 511, 0, 45, 25, 1'b0);
    run_phase($urandom_range(1, 6), $urandom_range(1, 12), 27, 27, 30, 1'b0);
    run_phase(16, 1, 0, 0, 25, 1'b1);
    run_phase(0, 300, 45, 0, 25, 1'b0);
    run_phase($urandom_range(1, 5), 0, 0, 45, 25, 1'b0);
    run_phase($urandom_range(1, 8), $urandom_range(1, 16), 27, 27, 40, 1'b0);

    wait_drained(SETTLE_CYCLES);
    if (mismatch_count == 0 && expected_potentials.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time,
             expected_potentials.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
